/* design/rvsc_pkg.sv */
// Package for the RV32I subset core: memory sizing, instruction field codes and
// the structures passed between the execute stage, the data memory and the top level.
// Depends on nothing.
package rvsc_pkg;

    localparam int DATA_MEM_BYTES = 4096;
    localparam int DMEM_AW        = $clog2(DATA_MEM_BYTES);
    localparam int DMEM_ROWS      = DATA_MEM_BYTES / 4;
    localparam int DMEM_ROW_W     = DMEM_AW - 2;
    localparam int RF_DEPTH       = 32;
    localparam int CLR_LEN        = (DMEM_ROWS > RF_DEPTH) ? DMEM_ROWS : RF_DEPTH;
    localparam int CLR_W          = $clog2(CLR_LEN);

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_JALR = 3'd0;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [4:0] X0_IDX = 5'd0;
    localparam logic [4:0] A0_IDX = 5'd10;
    localparam logic [4:0] A1_IDX = 5'd11;

    typedef struct packed {
        logic [31:0] npc;
        logic        halt;
        logic        bad;
        logic        wr;
        logic [4:0]  didx;
        logic [31:0] val;
        logic        load;
        logic        store;
        logic [31:0] maddr;
    } ex_res_t;

    typedef struct packed {
        logic               wr;
        logic               rd;
        logic [DMEM_AW-1:0] addr;
        logic [31:0]        data;
    } dmem_req_t;

endpackage

/* design/rvsc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the register file copies and the data memory byte lanes; no dependencies.
module rvsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/rvsc_exec.sv */
// Execute logic of the RV32I subset core: decode, ALU, branch compare and
// address generation for one instruction. Depends on rvsc_pkg.
module rvsc_exec
    import rvsc_pkg::*;
(
    input  logic [31:0] inst,
    input  logic [31:0] pc,
    input  logic [31:0] rs1_val,
    input  logic [31:0] rs2_val,
    output ex_res_t     res
);

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] sum_i;
    logic [31:0] alu;
    logic [31:0] npc;
    logic [31:0] maddr;
    logic        halt;
    logic        bad;
    logic        wcls;
    logic        load;
    logic        store;

    assign opc   = inst[6:0];
    assign rd    = inst[11:7];
    assign f3    = inst[14:12];
    assign f7    = inst[31:25];
    assign imm_i = {{20{inst[31]}}, inst[31:20]};
    assign imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
    assign imm_b = {{20{inst[31]}}, inst[7], inst[30:25], inst[11:8], 1'b0};
    assign sum_i = rs1_val + imm_i;

    always_comb
    begin
        npc   = pc + 32'd4;
        halt  = 1'b0;
        bad   = 1'b0;
        wcls  = 1'b0;
        alu   = '0;
        load  = 1'b0;
        store = 1'b0;
        maddr = sum_i;
        priority if (inst == 32'd0)
        begin
            halt = 1'b1;
        end
        else if (opc == OPC_OP)
        begin
            wcls = 1'b1;
            priority if (f3 == F3_ADD && f7 == F7_BASE)
            begin
                alu = rs1_val + rs2_val;
            end
            else if (f3 == F3_ADD && f7 == F7_ALT)
            begin
                alu = rs1_val - rs2_val;
            end
            else if (f3 == F3_XOR && f7 == F7_BASE)
            begin
                alu = rs1_val ^ rs2_val;
            end
            else if (f3 == F3_SR && f7 == F7_ALT)
            begin
                alu = $unsigned($signed(rs1_val) >>> rs2_val[4:0]);
            end
            else
            begin
                wcls = 1'b0;
                bad  = 1'b1;
            end
        end
        else if (opc == OPC_OPIMM)
        begin
            wcls = 1'b1;
            priority if (f3 == F3_ADD)
            begin
                alu = sum_i;
            end
            else if (f3 == F3_AND)
            begin
                alu = rs1_val & imm_i;
            end
            else
            begin
                wcls = 1'b0;
                bad  = 1'b1;
            end
        end
        else if (opc == OPC_LOAD && f3 == F3_WORD)
        begin
            load = 1'b1;
            wcls = 1'b1;
        end
        else if (opc == OPC_STORE && f3 == F3_WORD)
        begin
            store = 1'b1;
            maddr = rs1_val + imm_s;
        end
        else if (opc == OPC_BRANCH && f3 == F3_BLT)
        begin
            if ($signed(rs1_val) < $signed(rs2_val))
            begin
                npc = pc + imm_b;
            end
        end
        else if (opc == OPC_JALR && f3 == F3_JALR)
        begin
            wcls = 1'b1;
            alu  = pc + 32'd4;
            npc  = {sum_i[31:1], 1'b0};
        end
        else
        begin
            bad = 1'b1;
        end
    end

    always_comb
    begin
        res       = '0;
        res.npc   = npc;
        res.halt  = halt;
        res.bad   = bad;
        res.wr    = wcls && (rd != X0_IDX);
        res.didx  = wcls ? rd : X0_IDX;
        res.val   = (wcls && (rd != X0_IDX) && !load) ? alu : '0;
        res.load  = load;
        res.store = store;
        res.maddr = maddr;
    end

endmodule

/* design/rvsc_dmem.sv */
// Byte-addressed data memory of the RV32I subset core, built from four byte-lane RAMs
// so that an unaligned, wrapping word access costs one lane access each. Depends on
// rvsc_pkg and rvsc_ram.
module rvsc_dmem
    import rvsc_pkg::*;
(
    input  logic        clk,
    input  dmem_req_t   req,
    output logic [31:0] ld_data
);

    logic [DMEM_ROW_W-1:0] row [4];
    logic [1:0]            lane_k [4];
    logic [1:0]            lane_sel [4];
    logic [7:0]            wbyte [4];
    logic [7:0]            lane_rd [4];
    logic [1:0]            off_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            lane_k[j] = 2'(j) - req.addr[1:0];
            row[j]    = req.addr[DMEM_AW-1:2] + DMEM_ROW_W'(2'(j) < req.addr[1:0]);
            wbyte[j]  = req.data[8*lane_k[j] +: 8];
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        rvsc_ram #(
            .WIDTH(8),
            .DEPTH(DMEM_ROWS)
        ) u_lane (
            .clk   (clk),
            .we    (req.wr),
            .waddr (row[j]),
            .wdata (wbyte[j]),
            .re    (req.rd),
            .raddr (row[j]),
            .rdata (lane_rd[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            off_reg <= req.addr[1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lane_sel[k]        = 2'(k) + off_reg;
            ld_data[8*k +: 8]  = lane_rd[lane_sel[k]];
        end
    end

endmodule

/* design/rv32i_subset_core.sv */
// RV32I subset core: one instruction word in, one result word out per instruction.
// Depends on rvsc_pkg, rvsc_ram, rvsc_exec and rvsc_dmem.
//
// The core retires one instruction per clock unless the clearing pass or a stalled
// result register holds it up. The register file read is registered at acceptance,
// execution and the data memory access happen in the next cycle, and the write-back
// cycle loads the result register. Results of earlier instructions are forwarded, so
// dependent instructions may follow each other directly. After reset a clearing pass
// over max(DATA_MEM_BYTES / 4, 32) rows (1024 as built) zeroes the data memory and
// register file one row per cycle, and no instruction is taken during it.
// While the result register is full and stalled, new words are still taken until the
// write-back stage holds an instruction.
module rv32i_subset_core
    import rvsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        instr_valid,
    output logic        instr_stall,
    input  logic [31:0] instruction_word,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] next_pc,
    output logic        halted,
    output logic        illegal,
    output logic        reg_written,
    output logic [4:0]  dest_index,
    output logic [31:0] dest_value,
    output logic [31:0] a0_value,
    output logic [31:0] a1_value
);

    logic             adv;
    logic             take;
    logic             clr_active_reg;
    logic [CLR_W-1:0] clr_row_reg;
    logic [31:0]      pc_reg;

    logic             ex_valid_reg;
    logic             ex_valid_next;
    logic [31:0]      ex_inst_reg;
    logic [31:0]      rs1_ram;
    logic [31:0]      rs2_ram;
    logic [31:0]      rs1_val;
    logic [31:0]      rs2_val;
    ex_res_t          ex_res;

    logic             wb_valid_reg;
    logic [31:0]      wb_npc_reg;
    logic             wb_halt_reg;
    logic             wb_bad_reg;
    logic             wb_wr_reg;
    logic [4:0]       wb_didx_reg;
    logic [31:0]      wb_val_reg;
    logic             wb_load_reg;
    logic [31:0]      wb_value;
    logic [31:0]      ld_data;

    logic             lw_valid_reg;
    logic [4:0]       lw_idx_reg;
    logic [31:0]      lw_val_reg;

    logic             rf_we;
    logic [4:0]       rf_waddr;
    logic [31:0]      rf_wdata;
    dmem_req_t        dreq;

    logic             result_valid_reg;
    logic             result_valid_next;
    logic [31:0]      next_pc_reg;
    logic             halted_reg;
    logic             illegal_reg;
    logic             reg_written_reg;
    logic [4:0]       dest_index_reg;
    logic [31:0]      dest_value_reg;
    logic [31:0]      a0_value_reg;
    logic [31:0]      a0_value_next;
    logic [31:0]      a1_value_reg;
    logic [31:0]      a1_value_next;

    assign adv         = !(result_valid_reg && result_stall && wb_valid_reg);
    assign instr_stall = clr_active_reg || !adv;
    assign take        = instr_valid && !instr_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_row_reg <= clr_row_reg + CLR_W'(1);
            if (clr_row_reg == CLR_W'(CLR_LEN - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // The register file is held twice so that both source operands are read at once.
    assign rf_we    = clr_active_reg || (adv && wb_valid_reg && wb_wr_reg);
    assign rf_waddr = clr_active_reg ? clr_row_reg[4:0] : wb_didx_reg;
    assign rf_wdata = clr_active_reg ? '0 : wb_value;

    rvsc_ram #(
        .WIDTH(32),
        .DEPTH(RF_DEPTH)
    ) u_rf_rs1 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (adv),
        .raddr (instruction_word[19:15]),
        .rdata (rs1_ram)
    );

    rvsc_ram #(
        .WIDTH(32),
        .DEPTH(RF_DEPTH)
    ) u_rf_rs2 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (adv),
        .raddr (instruction_word[24:20]),
        .rdata (rs2_ram)
    );

    // The write-back stage is newer than the write made on the edge of the read.
    always_comb
    begin
        priority if (wb_valid_reg && wb_wr_reg && wb_didx_reg == ex_inst_reg[19:15])
        begin
            rs1_val = wb_value;
        end
        else if (lw_valid_reg && lw_idx_reg == ex_inst_reg[19:15])
        begin
            rs1_val = lw_val_reg;
        end
        else
        begin
            rs1_val = rs1_ram;
        end
        priority if (wb_valid_reg && wb_wr_reg && wb_didx_reg == ex_inst_reg[24:20])
        begin
            rs2_val = wb_value;
        end
        else if (lw_valid_reg && lw_idx_reg == ex_inst_reg[24:20])
        begin
            rs2_val = lw_val_reg;
        end
        else
        begin
            rs2_val = rs2_ram;
        end
    end

    rvsc_exec u_exec (
        .inst    (ex_inst_reg),
        .pc      (pc_reg),
        .rs1_val (rs1_val),
        .rs2_val (rs2_val),
        .res     (ex_res)
    );

    always_comb
    begin
        dreq      = '0;
        dreq.rd   = adv;
        dreq.wr   = clr_active_reg || (adv && ex_valid_reg && ex_res.store);
        dreq.addr = clr_active_reg ? {clr_row_reg[DMEM_ROW_W-1:0], 2'b00}
                                   : ex_res.maddr[DMEM_AW-1:0];
        dreq.data = clr_active_reg ? '0 : rs2_val;
    end

    rvsc_dmem u_dmem (
        .clk     (clk),
        .req     (dreq),
        .ld_data (ld_data)
    );

    assign wb_value = (wb_load_reg && wb_wr_reg) ? ld_data : wb_val_reg;

    assign ex_valid_next = adv ? take : ex_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            pc_reg       <= '0;
        end
        else
        begin
            ex_valid_reg <= ex_valid_next;
            if (adv)
            begin
                wb_valid_reg <= ex_valid_reg;
                lw_valid_reg <= wb_valid_reg && wb_wr_reg;
                if (ex_valid_reg)
                begin
                    pc_reg <= ex_res.npc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_inst_reg <= instruction_word;
            wb_npc_reg  <= ex_res.npc;
            wb_halt_reg <= ex_res.halt;
            wb_bad_reg  <= ex_res.bad;
            wb_wr_reg   <= ex_res.wr;
            wb_didx_reg <= ex_res.didx;
            wb_val_reg  <= ex_res.val;
            wb_load_reg <= ex_res.load;
            lw_idx_reg  <= wb_didx_reg;
            lw_val_reg  <= wb_value;
        end
    end

    assign a0_value_next = (wb_wr_reg && wb_didx_reg == A0_IDX) ? wb_value : a0_value_reg;
    assign a1_value_next = (wb_wr_reg && wb_didx_reg == A1_IDX) ? wb_value : a1_value_reg;
    assign result_valid_next = (adv && wb_valid_reg) || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            a0_value_reg     <= '0;
            a1_value_reg     <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (adv && wb_valid_reg)
            begin
                a0_value_reg <= a0_value_next;
                a1_value_reg <= a1_value_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && wb_valid_reg)
        begin
            next_pc_reg     <= wb_npc_reg;
            halted_reg      <= wb_halt_reg;
            illegal_reg     <= wb_bad_reg;
            reg_written_reg <= wb_wr_reg;
            dest_index_reg  <= wb_didx_reg;
            dest_value_reg  <= wb_value;
        end
    end

    assign result_valid = result_valid_reg;
    assign next_pc      = next_pc_reg;
    assign halted       = halted_reg;
    assign illegal      = illegal_reg;
    assign reg_written  = reg_written_reg;
    assign dest_index   = dest_index_reg;
    assign dest_value   = dest_value_reg;
    assign a0_value     = a0_value_reg;
    assign a1_value     = a1_value_reg;

`ifndef NO_ASSERTIONS
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && wb_valid_reg && wb_wr_reg) |-> (wb_didx_reg != X0_IDX))
        else $error("register x0 written by an instruction");

    a_halt_not_illegal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(halted && illegal))
        else $error("result word marked both halted and illegal");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !reg_written) |-> (dest_value == 32'd0))
        else $error("destination value nonzero without a register write");

    a_pipe_empty_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!ex_valid_reg && !wb_valid_reg && !result_valid_reg))
        else $error("instruction in flight during the clearing pass");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for rv32i_subset_core: drives instruction words and checks every
// result word against an in-bench model of the program counter, registers and data memory.
// Depends on rvsc_pkg and the rv32i_subset_core RTL.
module testbench;
    import rvsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_LIMIT = 4000;
    localparam int          HOLD_LEN   = 400;
    localparam int          TAIL_WAIT  = 8;
    localparam logic [31:0] HALT_WORD  = 32'h0000_0000;
    localparam logic [6:0]  OPC_NONE   = 7'h00;
    localparam logic [6:0]  OPC_LUI    = 7'h37;
    localparam logic [2:0]  F3_SHL     = 3'd1;
    localparam logic [2:0]  F3_BYTE    = 3'd0;
    localparam logic [2:0]  F3_BEQ     = 3'd0;
    localparam logic [6:0]  F7_MUL     = 7'h01;

    typedef struct {
        logic [31:0] npc;
        logic        halt;
        logic        bad;
        logic        wr;
        logic [4:0]  didx;
        logic [31:0] val;
        logic [31:0] a0;
        logic [31:0] a1;
    } retire_t;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        instr_valid      = 1'b0;
    logic        instr_stall;
    logic [31:0] instruction_word = '0;
    logic        result_valid;
    logic        result_stall     = 1'b0;
    logic [31:0] next_pc;
    logic        halted;
    logic        illegal;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] a0_value;
    logic [31:0] a1_value;

    logic [31:0] arch_pc;
    logic [31:0] arch_regs [RF_DEPTH];
    logic [7:0]  shadow_mem [DATA_MEM_BYTES];
    retire_t     pending_retires [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int mismatch_count;
    int sent_count;
    int checked_count;
    int halt_count;
    int illegal_count;
    int idle_cycles;

    logic [4:0] hot_regs [7] = '{5'd0, 5'd1, 5'd2, 5'd5, 5'd10, 5'd11, 5'd31};

    rv32i_subset_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .instr_valid      (instr_valid),
        .instr_stall      (instr_stall),
        .instruction_word (instruction_word),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .next_pc          (next_pc),
        .halted           (halted),
        .illegal          (illegal),
        .reg_written      (reg_written),
        .dest_index       (dest_index),
        .dest_value       (dest_value),
        .a0_value         (a0_value),
        .a1_value         (a1_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic void reset_model();
        arch_pc = '0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (shadow_mem[i]) shadow_mem[i] = '0;
    endfunction

    function automatic retire_t execute_word(input logic [31:0] w);
        logic [31:0] rs1v, rs2v, imm_i, imm_s, imm_b, addr, ba, val, npc;
        logic        wr, halt, bad;
        retire_t     r;
        rs1v  = arch_regs[w[19:15]];
        rs2v  = arch_regs[w[24:20]];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        npc   = arch_pc + 32'd4;
        val   = '0;
        wr    = 1'b0;
        halt  = 1'b0;
        bad   = 1'b0;
        if (w == HALT_WORD)
            halt = 1'b1;
        else if (w[6:0] == OPC_OP)
        begin
            wr = 1'b1;
            if (w[14:12] == F3_ADD && w[31:25] == F7_BASE)
                val = rs1v + rs2v;
            else if (w[14:12] == F3_ADD && w[31:25] == F7_ALT)
                val = rs1v - rs2v;
            else if (w[14:12] == F3_XOR && w[31:25] == F7_BASE)
                val = rs1v ^ rs2v;
            else if (w[14:12] == F3_SR && w[31:25] == F7_ALT)
                val = $signed(rs1v) >>> rs2v[4:0];
            else
            begin
                wr  = 1'b0;
                bad = 1'b1;
            end
        end
        else if (w[6:0] == OPC_OPIMM)
        begin
            wr = 1'b1;
            if (w[14:12] == F3_ADD)
                val = rs1v + imm_i;
            else if (w[14:12] == F3_AND)
                val = rs1v & imm_i;
            else
            begin
                wr  = 1'b0;
                bad = 1'b1;
            end
        end
        else if (w[6:0] == OPC_LOAD && w[14:12] == F3_WORD)
        begin
            addr = rs1v + imm_i;
            for (int k = 0; k < 4; k++)
            begin
                ba = addr + k;
                val[8*k +: 8] = shadow_mem[ba % DATA_MEM_BYTES];
            end
            wr = 1'b1;
        end
        else if (w[6:0] == OPC_STORE && w[14:12] == F3_WORD)
        begin
            addr = rs1v + imm_s;
            for (int k = 0; k < 4; k++)
            begin
                ba = addr + k;
                shadow_mem[ba % DATA_MEM_BYTES] = rs2v[8*k +: 8];
            end
        end
        else if (w[6:0] == OPC_BRANCH && w[14:12] == F3_BLT)
        begin
            if ($signed(rs1v) < $signed(rs2v))
                npc = arch_pc + imm_b;
        end
        else if (w[6:0] == OPC_JALR && w[14:12] == F3_JALR)
        begin
            val = arch_pc + 32'd4;
            wr  = 1'b1;
            npc = (rs1v + imm_i) & ~32'd1;
        end
        else
            bad = 1'b1;

        r.didx = wr ? w[11:7] : X0_IDX;
        if (wr && w[11:7] != X0_IDX)
            arch_regs[w[11:7]] = val;
        else
        begin
            wr  = 1'b0;
            val = '0;
        end
        arch_pc = npc;
        r.npc   = npc;
        r.halt  = halt;
        r.bad   = bad;
        r.wr    = wr;
        r.val   = val;
        r.a0    = arch_regs[A0_IDX];
        r.a1    = arch_regs[A1_IDX];
        return r;
    endfunction

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return hot_regs[$urandom_range(0, 6)];
    endfunction

    function automatic logic [31:0] random_word();
        logic [4:0]  rd, rs1, rs2;
        logic [11:0] imm;
        int          pick;
        rd   = pick_reg();
        rs1  = pick_reg();
        rs2  = pick_reg();
        imm  = 12'($urandom);
        pick = $urandom_range(0, 99);
        if (pick >= 51 && pick < 75)
        begin
            // Pull memory traffic toward a small window (base x0, offset under 256) so loads see earlier stores.
            if ($urandom_range(0, 1) == 0)
                rs1 = X0_IDX;
            if ($urandom_range(0, 1) == 0)
                imm = {4'h0, 6'($urandom), 2'b00};
        end
        if (pick < 8)
            return enc_r(F7_BASE, rs2, rs1, F3_ADD, rd);
        else if (pick < 15)
            return enc_r(F7_ALT, rs2, rs1, F3_ADD, rd);
        else if (pick < 22)
            return enc_r(F7_BASE, rs2, rs1, F3_XOR, rd);
        else if (pick < 30)
            return enc_r(F7_ALT, rs2, rs1, F3_SR, rd);
        else if (pick < 45)
            return enc_i(imm, rs1, F3_ADD, rd, OPC_OPIMM);
        else if (pick < 51)
            return enc_i(imm, rs1, F3_AND, rd, OPC_OPIMM);
        else if (pick < 63)
            return enc_i(imm, rs1, F3_WORD, rd, OPC_LOAD);
        else if (pick < 75)
            return enc_s(imm, rs2, rs1, F3_WORD);
        else if (pick < 82)
            return enc_b({imm, 1'b0}, rs2, rs1, F3_BLT);
        else if (pick < 86)
            return enc_i(imm, rs1, F3_JALR, rd, OPC_JALR);
        else if (pick < 88)
            return HALT_WORD;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return {25'($urandom_range(1, 2**25 - 1)), OPC_NONE};
            2: return enc_r(7'($urandom), rs2, rs1, 3'($urandom), rd);
            3: return enc_i(imm, rs1, 3'($urandom), rd, OPC_OPIMM);
            4: return enc_i(imm, rs1, 3'($urandom), rd, OPC_LOAD);
            5: return enc_s(imm, rs2, rs1, 3'($urandom));
            6: return enc_b({imm, 1'b0}, rs2, rs1, 3'($urandom));
            default: return enc_i(imm, rs1, 3'($urandom), rd, OPC_JALR);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
        end
        instr_valid      <= 1'b1;
        instruction_word <= w;
        @(posedge clk);
        while (instr_stall !== 1'b0)
            @(posedge clk);
        pending_retires.push_back(execute_word(w));
        sent_count++;
    endtask

    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served  <= hold_requests;
            hold_left    <= HOLD_LEN - 1;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        retire_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_retires.size() == 0)
                report_mismatch($sformatf("result word with none pending, next_pc %h", next_pc));
            else
            begin
                want = pending_retires.pop_front();
                checked_count++;
                if (want.halt)
                    halt_count++;
                if (want.bad)
                    illegal_count++;
                if (next_pc !== want.npc)
                    report_mismatch($sformatf("next_pc %h, wanted %h", next_pc, want.npc));
                if (halted !== want.halt)
                    report_mismatch($sformatf("halted %b, wanted %b", halted, want.halt));
                if (illegal !== want.bad)
                    report_mismatch($sformatf("illegal %b, wanted %b", illegal, want.bad));
                if (reg_written !== want.wr)
                    report_mismatch($sformatf("reg_written %b, wanted %b", reg_written, want.wr));
                if (dest_index !== want.didx)
                    report_mismatch($sformatf("dest_index %0d, wanted %0d",
                                              dest_index, want.didx));
                if (dest_value !== want.val)
                    report_mismatch($sformatf("dest_value %h, wanted %h", dest_value, want.val));
                if (a0_value !== want.a0)
                    report_mismatch($sformatf("a0_value %h, wanted %h", a0_value, want.a0));
                if (a1_value !== want.a1)
                    report_mismatch($sformatf("a1_value %h, wanted %h", a1_value, want.a1));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((instr_valid && instr_stall === 1'b0)
            || (result_valid === 1'b1 && result_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without a handshake", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_arith();
        send_word(enc_i(12'h7ff, X0_IDX, F3_ADD, A0_IDX, OPC_OPIMM));
        send_word(enc_i(12'h800, X0_IDX, F3_ADD, A1_IDX, OPC_OPIMM));
        send_word(enc_r(F7_BASE, A1_IDX, A0_IDX, F3_ADD, 5'd5));
        send_word(enc_r(F7_ALT, A0_IDX, A1_IDX, F3_ADD, A0_IDX));
        send_word(enc_r(F7_BASE, 5'd5, A0_IDX, F3_XOR, A1_IDX));
        send_word(enc_i(12'h03f, X0_IDX, F3_ADD, 5'd6, OPC_OPIMM));
        send_word(enc_r(F7_ALT, 5'd6, A0_IDX, F3_SR, A0_IDX));
        send_word(enc_r(F7_ALT, X0_IDX, A1_IDX, F3_SR, A1_IDX));
        send_word(enc_i(12'hf0f, 5'd5, F3_AND, A1_IDX, OPC_OPIMM));
        send_word(enc_r(F7_BASE, A1_IDX, A0_IDX, F3_ADD, X0_IDX));
    endtask

    task automatic test_memory();
        // The first pair straddles the top of the data memory and wraps to address zero.
        send_word(enc_s(12'hffe, A1_IDX, X0_IDX, F3_WORD));
        send_word(enc_i(12'hffe, X0_IDX, F3_WORD, A0_IDX, OPC_LOAD));
        send_word(enc_s(12'h7ff, A0_IDX, 5'd5, F3_WORD));
        send_word(enc_i(12'h7fe, X0_IDX, F3_WORD, A1_IDX, OPC_LOAD));
        send_word(enc_i(12'h000, X0_IDX, F3_WORD, A0_IDX, OPC_LOAD));
    endtask

    task automatic test_control();
        send_word(enc_b(13'h1000, X0_IDX, 5'd5, F3_BLT));
        send_word(enc_b(13'h0ffe, 5'd5, X0_IDX, F3_BLT));
        send_word(enc_i(12'hfff, 5'd5, F3_JALR, 5'd1, OPC_JALR));
        send_word(enc_i(12'hffc, X0_IDX, F3_JALR, X0_IDX, OPC_JALR));
        send_word(HALT_WORD);
    endtask

    task automatic test_illegal();
        send_word({25'd1, OPC_NONE});
        send_word(32'hffff_ffff);
        send_word(enc_r(F7_MUL, A1_IDX, A0_IDX, F3_ADD, A0_IDX));
        send_word(enc_i(12'h001, A0_IDX, F3_SHL, A0_IDX, OPC_OPIMM));
        send_word(enc_i(12'h000, X0_IDX, F3_BYTE, A0_IDX, OPC_LOAD));
        send_word(enc_s(12'h000, A0_IDX, X0_IDX, F3_BYTE));
        send_word(enc_b(13'h0008, X0_IDX, 5'd5, F3_BEQ));
        send_word(enc_i(12'h000, 5'd1, F3_SHL, A1_IDX, OPC_JALR));
        send_word({20'hfffff, A0_IDX, OPC_LUI});
    endtask

    task automatic test_random_stream(input int count, input int snd_pct, input int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int n = 0; n < count; n++)
            send_word(random_word());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        for (int n = 0; n < 60; n++)
            send_word(random_word());
    endtask

    initial
    begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 28;
        recv_idle_pct = 70;
        test_arith();
        test_memory();
        test_control();
        test_illegal();
        test_random_stream(500, 28, 70);
        test_random_stream(500, 70, 28);
        test_backpressure();
        test_random_stream(500, 0, 0);
        instr_valid <= 1'b0;
        while (pending_retires.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        $display("%0d instruction words sent, %0d result words checked, %0d halts, %0d illegal",
                 sent_count, checked_count, halt_count, illegal_count);
        $display("idling swept both sides, with one %0d-cycle result hold-off; %0d mismatches",
                 HOLD_LEN, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
